// ===== hdl/fpfa_pkg.sv =====
// Shared types and constants of the fixed-partition fit allocator.
package fpfa_pkg;

  localparam int NumBlocksDef = 8;
  localparam int SizeBitsDef  = 16;

  localparam int InDataW  = 32;
  localparam int OutDataW = 32;
  localparam int CfgDataW = 4;

  // Configuration register indexes
  localparam logic CFG_FIT_POLICY    = 1'b0;
  localparam logic CFG_ACTIVE_BLOCKS = 1'b1;

  localparam logic [3:0] ActiveBlocksRst = 4'd8;

  typedef enum logic [1:0] {
    MODE_DEFINE = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_DEFINED   = 3'd0,
    STAT_GRANTED   = 3'd1,
    STAT_NO_FIT    = 3'd2,
    STAT_QUERY     = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_e;

  // Control part of the item that walks down the cell chain
  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  found;
  } carry_ctl_t;

endpackage

// ===== hdl/fixed_partition_fit_allocator_unit.sv =====
// Top level of the fixed-partition fit allocator: cell chain, sequencer and output register.
//
// Usage:
//   Input items arrive on the s_axis group. tdata carries, from bit 0 up: mode (2),
//   block_index (3), request_size (16), owner_id (8). Mode define sets a partition's
//   size and frees it, mode allocate grants a free partition large enough for the
//   request (first fit or best fit), mode query reads one partition back.
//   Every item gives exactly one result item on the m_axis group.
//   An item walks the chain of NUM_BLOCKS cells, one cell per cycle; its result is
//   then registered in the sequencer and then in the output register.
//   One item is in flight at a time; s_axis_tready rises again as the result is
//   loaded into the output register, so the next item can be taken even while
//   that result still waits. When the receiver stalls, the finished result holds
//   in the sequencer until the output register frees; the grant is written back
//   to its cell in that same cycle. Reset frees every partition, clears owners,
//   selects first fit and makes all eight table entries active. Partition sizes
//   are undefined until defined. Configuration (cfg_we_i, cfg_addr_i, cfg_wdata_i)
//   must be written only while idle; the block itself does not enforce this.
module fixed_partition_fit_allocator_unit #(
  parameter int NUM_BLOCKS = fpfa_pkg::NumBlocksDef,
  parameter int SIZE_BITS  = fpfa_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [fpfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // mode[1:0], block_index[4:2], request_size[20:5], owner_id[28:21], zero fill
  input  logic [fpfa_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], chosen_index[5:3], chosen_size[21:6], chosen_busy[22],
  // chosen_owner[30:23], zero fill
  output logic [fpfa_pkg::OutDataW-1:0] m_axis_tdata
);
  import fpfa_pkg::*;

  localparam int IdxW = $clog2(NUM_BLOCKS);
  localparam int ExtW = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER
  } state_e;

  state_e state_q;

  // configuration
  logic       fit_policy_q;
  logic [3:0] active_blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q    <= 1'b0;
      active_blocks_q <= ActiveBlocksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FIT_POLICY:    fit_policy_q    <= cfg_wdata_i[0];
        CFG_ACTIVE_BLOCKS: active_blocks_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // unpack the input item
  logic                 s_acc;
  logic [ExtW-1:0]      req_ext;
  logic [SIZE_BITS-1:0] req_in;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign req_ext       = ExtW'(s_axis_tdata[20:5]);
  assign req_in        = req_ext[SIZE_BITS-1:0];

  // chain links: link 0 is the launch register, link NUM_BLOCKS leaves the last cell
  carry_ctl_t           ch_ctl   [NUM_BLOCKS+1];
  logic [2:0]           ch_tgt   [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] ch_req   [NUM_BLOCKS+1];
  logic [7:0]           ch_owner [NUM_BLOCKS+1];
  logic [IdxW-1:0]      ch_bidx  [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] ch_bsize [NUM_BLOCKS+1];
  logic                 ch_bbusy [NUM_BLOCKS+1];
  logic [7:0]           ch_bown  [NUM_BLOCKS+1];

  carry_ctl_t           launch_ctl_q;
  logic [2:0]           launch_tgt_q;
  logic [SIZE_BITS-1:0] launch_req_q;
  logic [7:0]           launch_owner_q;

  assign ch_ctl[0]   = launch_ctl_q;
  assign ch_tgt[0]   = launch_tgt_q;
  assign ch_req[0]   = launch_req_q;
  assign ch_owner[0] = launch_owner_q;
  assign ch_bidx[0]  = '0;
  assign ch_bsize[0] = '0;
  assign ch_bbusy[0] = 1'b0;
  assign ch_bown[0]  = 8'd0;

  // grant write-back, pulsed when the result enters the output register
  logic            commit_en;
  logic            commit_pend_q;
  logic [IdxW-1:0] commit_idx_q;
  logic [7:0]      commit_owner_q;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    fpfa_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .CELL_IDX   (g),
      .IDX_W      (IdxW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .fit_policy_i    (fit_policy_q),
      .active_blocks_i (active_blocks_q),
      .commit_en_i     (commit_en),
      .commit_idx_i    (commit_idx_q),
      .commit_owner_i  (commit_owner_q),
      .ctl_i           (ch_ctl[g]),
      .tgt_i           (ch_tgt[g]),
      .req_i           (ch_req[g]),
      .owner_i         (ch_owner[g]),
      .best_idx_i      (ch_bidx[g]),
      .best_size_i     (ch_bsize[g]),
      .best_busy_i     (ch_bbusy[g]),
      .best_owner_i    (ch_bown[g]),
      .ctl_o           (ch_ctl[g+1]),
      .tgt_o           (ch_tgt[g+1]),
      .req_o           (ch_req[g+1]),
      .owner_o         (ch_owner[g+1]),
      .best_idx_o      (ch_bidx[g+1]),
      .best_size_o     (ch_bsize[g+1]),
      .best_busy_o     (ch_bbusy[g+1]),
      .best_owner_o    (ch_bown[g+1])
    );
  end

  // form the result from the item leaving the chain
  carry_ctl_t      tail_ctl;
  logic [ExtW-1:0] tail_size_ext;
  status_e         res_status;
  logic [2:0]      res_index;
  logic [15:0]     res_size;
  logic            res_busy;
  logic [7:0]      res_owner;
  logic            res_commit;

  assign tail_ctl      = ch_ctl[NUM_BLOCKS];
  assign tail_size_ext = ExtW'(ch_bsize[NUM_BLOCKS]);

  always_comb begin
    res_status = STAT_BAD_INDEX;
    res_index  = 3'd0;
    res_size   = 16'd0;
    res_busy   = 1'b0;
    res_owner  = 8'd0;
    res_commit = 1'b0;
    unique case (tail_ctl.mode)
      MODE_DEFINE, MODE_QUERY: begin
        if (tail_ctl.found) begin
          res_status = (tail_ctl.mode == MODE_DEFINE) ? STAT_DEFINED : STAT_QUERY;
          res_index  = 3'(ch_bidx[NUM_BLOCKS]);
          res_size   = tail_size_ext[15:0];
          res_busy   = ch_bbusy[NUM_BLOCKS];
          res_owner  = ch_bown[NUM_BLOCKS];
        end
      end
      MODE_ALLOC: begin
        if (tail_ctl.found) begin
          res_status = STAT_GRANTED;
          res_index  = 3'(ch_bidx[NUM_BLOCKS]);
          res_size   = tail_size_ext[15:0];
          res_busy   = 1'b1;
          res_owner  = ch_owner[NUM_BLOCKS];
          res_commit = 1'b1;
        end else begin
          res_status = STAT_NO_FIT;
        end
      end
      default: ;
    endcase
  end

  // sequencer and output register
  logic [OutDataW-1:0] hold_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                out_free;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign commit_en = (state_q == ST_DELIVER) && out_free && commit_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      launch_ctl_q  <= '0;
      commit_pend_q <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      // launch pulses for one cycle per accepted item
      launch_ctl_q.valid <= s_acc;
      // load a finished result, or drop the one just taken
      if (state_q == ST_DELIVER && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            launch_ctl_q.mode  <= mode_e'(s_axis_tdata[1:0]);
            launch_ctl_q.found <= 1'b0;
            state_q            <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail_ctl.valid) begin
            commit_pend_q <= res_commit;
            state_q       <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (out_free) begin
            commit_pend_q <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      launch_tgt_q   <= s_axis_tdata[4:2];
      launch_req_q   <= req_in;
      launch_owner_q <= s_axis_tdata[28:21];
    end
    if (state_q == ST_SCAN && tail_ctl.valid) begin
      hold_q         <= {1'b0, res_owner, res_busy, res_size, res_index, res_status};
      commit_idx_q   <= ch_bidx[NUM_BLOCKS];
      commit_owner_q <= ch_owner[NUM_BLOCKS];
    end
    if (state_q == ST_DELIVER && out_free) begin
      m_data_q <= hold_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== hdl/fpfa_cell.sv =====
// One partition cell: holds size, busy flag and owner, and passes the scan item on.
module fpfa_cell #(
  parameter int NUM_BLOCKS = fpfa_pkg::NumBlocksDef,
  parameter int SIZE_BITS  = fpfa_pkg::SizeBitsDef,
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fit_policy_i,
  input  logic [3:0]           active_blocks_i,
  input  logic                 commit_en_i,
  input  logic [IDX_W-1:0]     commit_idx_i,
  input  logic [7:0]           commit_owner_i,
  input  fpfa_pkg::carry_ctl_t ctl_i,
  input  logic [2:0]           tgt_i,
  input  logic [SIZE_BITS-1:0] req_i,
  input  logic [7:0]           owner_i,
  input  logic [IDX_W-1:0]     best_idx_i,
  input  logic [SIZE_BITS-1:0] best_size_i,
  input  logic                 best_busy_i,
  input  logic [7:0]           best_owner_i,
  output fpfa_pkg::carry_ctl_t ctl_o,
  output logic [2:0]           tgt_o,
  output logic [SIZE_BITS-1:0] req_o,
  output logic [7:0]           owner_o,
  output logic [IDX_W-1:0]     best_idx_o,
  output logic [SIZE_BITS-1:0] best_size_o,
  output logic                 best_busy_o,
  output logic [7:0]           best_owner_o
);
  import fpfa_pkg::*;

  localparam logic [6:0]       MeIdx   = 7'(CELL_IDX);
  localparam logic [IDX_W-1:0] MeIdxIw = IDX_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 busy_q, busy_d;
  logic [7:0]           own_q, own_d;

  carry_ctl_t           ctl_q, ctl_d;
  logic [2:0]           tgt_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [7:0]           owner_q;
  logic [IDX_W-1:0]     bidx_q, bidx_d;
  logic [SIZE_BITS-1:0] bsize_q, bsize_d;
  logic                 bbusy_q, bbusy_d;
  logic [7:0]           bown_q, bown_d;

  logic active, hit;

  assign active = {3'b000, active_blocks_i} > MeIdx;
  assign hit    = {4'b0000, tgt_i} == MeIdx;

  always_comb begin
    size_d  = size_q;
    busy_d  = busy_q;
    own_d   = own_q;
    ctl_d   = ctl_i;
    bidx_d  = best_idx_i;
    bsize_d = best_size_i;
    bbusy_d = best_busy_i;
    bown_d  = best_owner_i;
    if (commit_en_i && commit_idx_i == MeIdxIw) begin
      busy_d = 1'b1;
      own_d  = commit_owner_i;
    end
    if (ctl_i.valid && active) begin
      unique case (ctl_i.mode)
        MODE_DEFINE: begin
          if (hit) begin
            size_d      = req_i;
            busy_d      = 1'b0;
            own_d       = 8'd0;
            ctl_d.found = 1'b1;
            bidx_d      = MeIdxIw;
            bsize_d     = req_i;
            bbusy_d     = 1'b0;
            bown_d      = 8'd0;
          end
        end
        MODE_QUERY: begin
          if (hit) begin
            ctl_d.found = 1'b1;
            bidx_d      = MeIdxIw;
            bsize_d     = size_q;
            bbusy_d     = busy_q;
            bown_d      = own_q;
          end
        end
        MODE_ALLOC: begin
          // first fit keeps the earliest hit; best fit replaces on strictly smaller
          if (!busy_q && size_q >= req_i &&
              (!ctl_i.found || (fit_policy_i && size_q < best_size_i))) begin
            ctl_d.found = 1'b1;
            bidx_d      = MeIdxIw;
            bsize_d     = size_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      own_q  <= 8'd0;
      ctl_q  <= '0;
    end else begin
      busy_q <= busy_d;
      own_q  <= own_d;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    tgt_q   <= tgt_i;
    req_q   <= req_i;
    owner_q <= owner_i;
    bidx_q  <= bidx_d;
    bsize_q <= bsize_d;
    bbusy_q <= bbusy_d;
    bown_q  <= bown_d;
  end

  assign ctl_o        = ctl_q;
  assign tgt_o        = tgt_q;
  assign req_o        = req_q;
  assign owner_o      = owner_q;
  assign best_idx_o   = bidx_q;
  assign best_size_o  = bsize_q;
  assign best_busy_o  = bbusy_q;
  assign best_owner_o = bown_q;

endmodule

// ===== dv/fixed_partition_fit_allocator_unit_test.sv =====
// Self-checking testbench of the fixed-partition fit allocator with its own partition table model.
module fixed_partition_fit_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpfa_pkg::*;

  localparam int NumParts      = NumBlocksDef;
  localparam int DrainCycles   = NumParts + 8;     // block latency plus margin
  localparam int HoldOffCycles = 300;              // long receiver hold-off
  localparam int CycleLimit    = 1_000_000;
  localparam int RandPhases    = 12;
  localparam int PhaseItems    = 137;

  // Mode code that the package leaves unnamed; the block must answer it as bad index
  localparam logic [1:0] ModeSpare = 2'd3;

  // One result item, unpacked
  typedef struct packed {
    logic [7:0]  owner;
    logic        busy;
    logic [15:0] size;
    logic [2:0]  idx;
    status_e     status;
  } outcome_t;

  // Partition table shadow: predicts each result and checks the block against it
  class alloc_scoreboard;
    logic [15:0] size_tbl [NumParts];
    logic        busy_tbl [NumParts];
    logic [7:0]  owner_tbl[NumParts];
    logic        policy;
    logic [3:0]  active;
    outcome_t    pending[$];
    int          errors;
    int          results_seen;

    function new();
      for (int j = 0; j < NumParts; j++) begin
        size_tbl[j]  = '0;
        busy_tbl[j]  = 1'b0;
        owner_tbl[j] = '0;
      end
      policy       = 1'b0;
      active       = ActiveBlocksRst;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic addr, logic [3:0] val);
      if (addr == CFG_FIT_POLICY) policy = val[0];
      else active = val;
    endfunction

    // Apply one item to the shadow table and return the result it causes
    function outcome_t predict_outcome(logic [31:0] d);
      logic [1:0]  mode;
      logic [2:0]  idx;
      logic [15:0] req;
      logic [7:0]  own;
      int          n;
      int          best;
      bit          found;
      outcome_t    o;
      mode  = d[1:0];
      idx   = d[4:2];
      req   = d[20:5];
      own   = d[28:21];
      n     = (active > NumParts) ? NumParts : active;
      o     = '0;
      found = 1'b0;
      best  = 0;
      case (mode)
        MODE_DEFINE, MODE_QUERY: begin
          if (idx >= n) begin
            o.status = STAT_BAD_INDEX;
          end else begin
            if (mode == MODE_DEFINE) begin
              size_tbl[idx]  = req;
              busy_tbl[idx]  = 1'b0;
              owner_tbl[idx] = '0;
              o.status = STAT_DEFINED;
            end else begin
              o.status = STAT_QUERY;
            end
            o.idx   = idx;
            o.size  = size_tbl[idx];
            o.busy  = busy_tbl[idx];
            o.owner = owner_tbl[idx];
          end
        end
        MODE_ALLOC: begin
          // first fit keeps the lowest hit; best fit replaces only on a strictly smaller size
          for (int j = 0; j < NumParts; j++) begin
            if (j < n && !busy_tbl[j] && size_tbl[j] >= req) begin
              if (!found) begin
                found = 1'b1;
                best  = j;
              end else if (policy && size_tbl[j] < size_tbl[best]) begin
                best = j;
              end
            end
          end
          if (!found) begin
            o.status = STAT_NO_FIT;
          end else begin
            busy_tbl[best]  = 1'b1;
            owner_tbl[best] = own;
            o.status = STAT_GRANTED;
            o.idx    = best[2:0];
            o.size   = size_tbl[best];
            o.busy   = 1'b1;
            o.owner  = own;
          end
        end
        default: o.status = STAT_BAD_INDEX;
      endcase
      return o;
    endfunction

    function void note_item(logic [31:0] d);
      pending.push_back(predict_outcome(d));
    endfunction

    task report_mismatch(string what, int got, int want_v);
      errors++;
      $display("[%0t] result %0d: %s got %0d, expected %0d",
               $realtime, results_seen, what, got, want_v);
    endtask

    task check_result(logic [31:0] d);
      outcome_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", d, 0);
        return;
      end
      want = pending.pop_front();
      if (d[2:0]   != want.status) report_mismatch("status", d[2:0], want.status);
      if (d[5:3]   != want.idx)    report_mismatch("chosen_index", d[5:3], want.idx);
      if (d[21:6]  != want.size)   report_mismatch("chosen_size", d[21:6], want.size);
      if (d[22]    != want.busy)   report_mismatch("chosen_busy", d[22], want.busy);
      if (d[30:23] != want.owner)  report_mismatch("chosen_owner", d[30:23], want.owner);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  alloc_scoreboard sb = new();

  bit no_idle;            // phase without any idling on either side
  int hold_off_events;    // bump to ask the receiver for a long hold-off
  int cycles;

  fixed_partition_fit_allocator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mode[1:0], block_index[4:2], request_size[20:5], owner_id[28:21], zero fill
  function automatic logic [31:0] pack_item(logic [1:0] m, logic [2:0] i,
                                            logic [15:0] s, logic [7:0] o);
    return {3'b000, o, s, i, m};
  endfunction

  // Small multiples of 16 so fits, misfits and best-fit ties all occur; extremes now and then
  function automatic logic [15:0] random_size();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) return 16'h0000;
    if (s == 1) return 16'hFFFF;
    if (s == 2) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 16) * 16);
  endfunction

  function automatic logic [31:0] random_item();
    int          r;
    logic [1:0]  m;
    r = $urandom_range(0, 99);
    if (r < 30) m = MODE_DEFINE;
    else if (r < 70) m = MODE_ALLOC;
    else if (r < 95) m = MODE_QUERY;
    else m = ModeSpare;
    return pack_item(m, 3'($urandom_range(0, 7)), random_size(), 8'($urandom_range(0, 255)));
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(logic [31:0] d);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(d);
  endtask

  // Send, then idle for a random gap
  task automatic offer(logic [31:0] d);
    int g;
    send_item(d);
    g = no_idle ? 0 : pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid, wait for every pending result, then let the block go quiet
  task automatic drain_block();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_register(addr, val);
  endtask

  // Receiver ready: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left    = 0;
    hold_left     = 0;
    hold_seen     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_off_events) begin
        hold_seen = hold_off_events;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        stall_left = (no_idle || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
        m_axis_tready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Check every result item taken at a rising edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog: end the run if the block hangs
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int active_plan[RandPhases] = '{8, 1, 4, 0, 15, 8, 2, 7, 8, 3, 6, 8};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_FIT_POLICY;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    no_idle         = 1'b0;
    hold_off_events = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // Define every partition first so no undefined size is ever read; include both size extremes
    offer(pack_item(MODE_DEFINE, 3'd0, 16'd100, 8'hFF));
    offer(pack_item(MODE_DEFINE, 3'd1, 16'd50, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd2, 16'hFFFF, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd3, 16'd0, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd4, 16'd50, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd5, 16'd200, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd6, 16'd30, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd7, 16'hFFFF, 8'h00));
    offer(pack_item(MODE_QUERY, 3'd3, 16'h0000, 8'h00));
    offer(pack_item(MODE_QUERY, 3'd7, 16'hFFFF, 8'hFF));
    // First fit: zero-size request, ignored index, largest request, then no fit
    offer(pack_item(MODE_ALLOC, 3'd7, 16'd0, 8'h00));
    offer(pack_item(MODE_ALLOC, 3'd0, 16'd60, 8'hFF));
    offer(pack_item(MODE_ALLOC, 3'd3, 16'hFFFF, 8'h5A));
    offer(pack_item(MODE_ALLOC, 3'd0, 16'hFFFF, 8'h01));
    offer(pack_item(ModeSpare, 3'd7, 16'hFFFF, 8'hFF));
    offer(pack_item(MODE_QUERY, 3'd2, 16'd0, 8'h00));
    // Redefine a busy partition: frees it and clears the owner
    offer(pack_item(MODE_DEFINE, 3'd2, 16'd40, 8'hAA));
    drain_block();

    // Best fit: tie on size goes to the lower index
    write_reg(CFG_FIT_POLICY, 4'd1);
    offer(pack_item(MODE_ALLOC, 3'd0, 16'd45, 8'h01));
    offer(pack_item(MODE_ALLOC, 3'd0, 16'd45, 8'h02));
    offer(pack_item(MODE_ALLOC, 3'd5, 16'd0, 8'h03));
    drain_block();

    // Active count smaller than the table: indexes beyond it are bad
    write_reg(CFG_ACTIVE_BLOCKS, 4'd2);
    offer(pack_item(MODE_QUERY, 3'd5, 16'd0, 8'h00));
    offer(pack_item(MODE_DEFINE, 3'd7, 16'd9, 8'h00));
    drain_block();

    // No partition in use at all
    write_reg(CFG_ACTIVE_BLOCKS, 4'd0);
    offer(pack_item(MODE_ALLOC, 3'd0, 16'd0, 8'h00));
    offer(pack_item(MODE_QUERY, 3'd0, 16'd0, 8'h00));
    drain_block();

    // Active count above the table size is capped
    write_reg(CFG_ACTIVE_BLOCKS, 4'd15);
    offer(pack_item(MODE_QUERY, 3'd7, 16'd0, 8'h00));
    drain_block();

    // Random phases, each with its own setting
    for (int ph = 0; ph < RandPhases; ph++) begin
      write_reg(CFG_FIT_POLICY, 4'(ph % 2));
      write_reg(CFG_ACTIVE_BLOCKS, 4'(active_plan[ph]));
      no_idle = (ph % 4 == 2);
      if (ph == 1 || ph == 8) hold_off_events++;   // fill the block while the receiver holds off
      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == 5 && k == PhaseItems / 2) begin
          // pause the sender until everything has come back
          @(negedge clk_i);
          s_axis_tvalid = 1'b0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        offer(random_item());
      end
      drain_block();
    end

    no_idle = 1'b0;
    drain_block();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== fixed_partition_fit_allocator_unit.f =====
hdl/fpfa_pkg.sv
hdl/fpfa_cell.sv
hdl/fixed_partition_fit_allocator_unit.sv
dv/fixed_partition_fit_allocator_unit_test.sv
